/* hw/rtl/yuv420_pkg.sv */
// shared constants and types for the rgb to yuv 4:2:0 converter
`default_nettype none

package yuv420_pkg;

	// configuration port
	localparam int CFG_DATA_W  = 13;
	localparam int CFG_INDEX_W = 2;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1
	} cfg_reg_t;

	// frame geometry
	localparam int MAX_DIMENSION_DEF = 4096;
	localparam int IMAGE_WIDTH_RST   = 640;
	localparam int IMAGE_HEIGHT_RST  = 480;

	// pixel component width
	localparam int COMP_W = 8;

	// bt.601 integer coefficients
	localparam int Y_R   = 66;
	localparam int Y_G   = 129;
	localparam int Y_B   = 25;
	localparam int CB_R  = 38;
	localparam int CB_G  = 74;
	localparam int CB_B  = 112;
	localparam int CR_R  = 112;
	localparam int CR_G  = 94;
	localparam int CR_B  = 18;
	localparam int ROUND = 128;
	localparam int Y_OFS = 16;
	localparam int C_OFS = 128;
	localparam int SHIFT = 8;
	localparam int C_BIAS = 32768;
	localparam int SAT_MAX = 255;

	// per-pixel position tag from the position tracker
	typedef struct packed {
		logic keep;
		logic chroma_valid;
		logic frame_end;
	} pix_tag_t;

endpackage

`default_nettype wire

/* hw/rtl/yuv420_if.sv */
// valid/ready channel interfaces for rgb pixels in and yuv results out
`default_nettype none

interface yuv420_rgb_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface yuv420_yuv_if;
	logic       valid;
	logic       ready;
	logic [7:0] luma;
	logic       chroma_valid;
	logic [7:0] chroma_blue;
	logic [7:0] chroma_red;
	logic       frame_end;

	modport source (
		output valid, output luma, output chroma_valid, output chroma_blue,
		output chroma_red, output frame_end, input ready
	);
	modport sink (
		input valid, input luma, input chroma_valid, input chroma_blue,
		input chroma_red, input frame_end, output ready
	);
endinterface

`default_nettype wire

/* hw/rtl/yuv420_pos.sv */
// frame geometry registers and raster position counters
`default_nettype none

module yuv420_pos #(
	parameter int MAX_DIMENSION = yuv420_pkg::MAX_DIMENSION_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [yuv420_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [yuv420_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                               advance,
	output yuv420_pkg::pix_tag_t                    tag
);
	import yuv420_pkg::*;

	localparam int CW      = $clog2(MAX_DIMENSION);
	localparam int DW      = $clog2(MAX_DIMENSION + 1);
	localparam int CMPW    = (DW > CFG_DATA_W) ? DW : CFG_DATA_W;
	localparam int WidthRst  = (IMAGE_WIDTH_RST > MAX_DIMENSION) ? MAX_DIMENSION
		: IMAGE_WIDTH_RST;
	localparam int HeightRst = (IMAGE_HEIGHT_RST > MAX_DIMENSION) ? MAX_DIMENSION
		: IMAGE_HEIGHT_RST;

	logic [DW-1:0]   width_q;
	logic [DW-1:0]   height_q;
	logic [CW-1:0]   col_q;
	logic [CW-1:0]   row_q;
	logic [CMPW-1:0] cfg_ext;
	logic [DW-1:0]   dim_eff;
	logic [DW-1:0]   width_even;
	logic [DW-1:0]   height_even;
	logic [DW-1:0]   col_ext;
	logic [DW-1:0]   row_ext;
	logic [DW-1:0]   col_nx;
	logic [DW-1:0]   row_nx;
	logic            cfg_hit;

	// written value limited to 1..max, stored in that form
	always_comb begin
		cfg_ext = CMPW'(cfg_data);
		if (cfg_ext == '0) begin
			dim_eff = DW'(1);
		end else if (cfg_ext > CMPW'(MAX_DIMENSION)) begin
			dim_eff = DW'(MAX_DIMENSION);
		end else begin
			dim_eff = cfg_ext[DW-1:0];
		end
	end

	assign cfg_hit = cfg_we && ((cfg_index == REG_IMAGE_WIDTH)
		|| (cfg_index == REG_IMAGE_HEIGHT));

	// geometry registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DW'(WidthRst);
			height_q <= DW'(HeightRst);
		end else if (cfg_we) begin
			if (cfg_index == REG_IMAGE_WIDTH) begin
				width_q <= dim_eff;
			end
			if (cfg_index == REG_IMAGE_HEIGHT) begin
				height_q <= dim_eff;
			end
		end
	end

	// cropped dimensions and position compares
	always_comb begin
		width_even  = {width_q[DW-1:1], 1'b0};
		height_even = {height_q[DW-1:1], 1'b0};
		col_ext     = DW'(col_q);
		row_ext     = DW'(row_q);
		col_nx      = col_ext + DW'(1);
		row_nx      = row_ext + DW'(1);
		tag.keep    = (col_ext < width_even) && (row_ext < height_even);
		tag.chroma_valid = tag.keep && !col_q[0] && !row_q[0];
		tag.frame_end    = tag.keep && (col_ext == width_even - DW'(1))
			&& (row_ext == height_even - DW'(1));
	end

	// raster counters, a geometry write starts a new frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_hit) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (col_nx >= width_q) begin
				col_q <= '0;
				row_q <= (row_nx >= height_q) ? '0 : row_nx[CW-1:0];
			end else begin
				col_q <= col_nx[CW-1:0];
			end
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/yuv420_csc.sv */
// bt.601 integer color space conversion with rounding and saturation
`default_nettype none

module yuv420_csc (
	input  wire logic [yuv420_pkg::COMP_W-1:0] red,
	input  wire logic [yuv420_pkg::COMP_W-1:0] green,
	input  wire logic [yuv420_pkg::COMP_W-1:0] blue,
	input  wire logic                          chroma_valid,
	output logic [yuv420_pkg::COMP_W-1:0]      luma,
	output logic [yuv420_pkg::COMP_W-1:0]      chroma_blue,
	output logic [yuv420_pkg::COMP_W-1:0]      chroma_red
);
	import yuv420_pkg::*;

	localparam int SW = 17;

	logic [SW-1:0] r_ext;
	logic [SW-1:0] g_ext;
	logic [SW-1:0] b_ext;
	logic [SW-1:0] y_sum;
	logic [SW-1:0] y_val;
	logic [SW-1:0] cb_pos;
	logic [SW-1:0] cb_neg;
	logic [SW-1:0] cr_pos;
	logic [SW-1:0] cr_neg;
	logic [SW-1:0] cb_val;
	logic [SW-1:0] cr_val;

	// constant multiplies and rounded sums
	always_comb begin
		r_ext  = SW'(red);
		g_ext  = SW'(green);
		b_ext  = SW'(blue);
		y_sum  = SW'(Y_R) * r_ext + SW'(Y_G) * g_ext + SW'(Y_B) * b_ext + SW'(ROUND);
		y_val  = (y_sum >> SHIFT) + SW'(Y_OFS);
		cb_pos = SW'(CB_B) * b_ext + SW'(ROUND + C_BIAS);
		cb_neg = SW'(CB_R) * r_ext + SW'(CB_G) * g_ext;
		cr_pos = SW'(CR_R) * r_ext + SW'(ROUND + C_BIAS);
		cr_neg = SW'(CR_G) * g_ext + SW'(CR_B) * b_ext;
		cb_val = (cb_pos < cb_neg) ? '0 : ((cb_pos - cb_neg) >> SHIFT);
		cr_val = (cr_pos < cr_neg) ? '0 : ((cr_pos - cr_neg) >> SHIFT);
	end

	// saturate to eight bits, chroma zero off the sample grid
	always_comb begin
		luma = (y_val > SW'(SAT_MAX)) ? COMP_W'(SAT_MAX) : y_val[COMP_W-1:0];
		chroma_blue = '0;
		chroma_red  = '0;
		if (chroma_valid) begin
			chroma_blue = (cb_val > SW'(SAT_MAX)) ? COMP_W'(SAT_MAX)
				: cb_val[COMP_W-1:0];
			chroma_red  = (cr_val > SW'(SAT_MAX)) ? COMP_W'(SAT_MAX)
				: cr_val[COMP_W-1:0];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/rgb_to_yuv420_converter.sv */
// top level of the rgb888 to yuv 4:2:0 converter
//
// channel     dir   payload
// pixel_in    in    red, green, blue
// pixel_out   out   luma, chroma_valid, chroma_blue, chroma_red, frame_end
// cfg_*       in    image_width (index 0), image_height (index 1)
//
// one pixel per cycle sustained while pixel_out is ready; a kept pixel's result passes through
// the input register, then the result register, before it can be taken
// pixels in the cropped last column or row are counted and dropped
// arst_n clears valids and counters; geometry resets to 640 x 480
// a stalled output holds its result while one more pixel waits in the input register
`default_nettype none

module rgb_to_yuv420_converter #(
	parameter int MAX_DIMENSION = yuv420_pkg::MAX_DIMENSION_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [yuv420_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [yuv420_pkg::CFG_DATA_W-1:0]  cfg_data,
	yuv420_rgb_if.sink                              pixel_in,
	yuv420_yuv_if.source                            pixel_out
);
	import yuv420_pkg::*;

	pix_tag_t          tag;
	pix_tag_t          tag_s1;
	logic              valid_s1;
	logic [COMP_W-1:0] red_s1;
	logic [COMP_W-1:0] green_s1;
	logic [COMP_W-1:0] blue_s1;
	logic              valid_s2;
	logic [COMP_W-1:0] luma_s2;
	logic              chroma_valid_s2;
	logic [COMP_W-1:0] chroma_blue_s2;
	logic [COMP_W-1:0] chroma_red_s2;
	logic              frame_end_s2;
	logic [COMP_W-1:0] luma_c;
	logic [COMP_W-1:0] chroma_blue_c;
	logic [COMP_W-1:0] chroma_red_c;
	logic              s2_load;
	logic              in_ready;
	logic              in_xfer;

	// handshake: result register frees up when empty or taken
	assign s2_load  = !valid_s2 || pixel_out.ready;
	assign in_ready = !valid_s1 || s2_load;
	assign in_xfer  = pixel_in.valid && in_ready;
	assign pixel_in.ready = in_ready;

	yuv420_pos #(
		.MAX_DIMENSION(MAX_DIMENSION)
	) u_pos (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.advance  (in_xfer),
		.tag      (tag)
	);

	// input register, dropped pixels never become valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_xfer && tag.keep;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			red_s1   <= pixel_in.red;
			green_s1 <= pixel_in.green;
			blue_s1  <= pixel_in.blue;
			tag_s1   <= tag;
		end
	end

	yuv420_csc u_csc (
		.red         (red_s1),
		.green       (green_s1),
		.blue        (blue_s1),
		.chroma_valid(tag_s1.chroma_valid),
		.luma        (luma_c),
		.chroma_blue (chroma_blue_c),
		.chroma_red  (chroma_red_c)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_load) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load && valid_s1) begin
			luma_s2         <= luma_c;
			chroma_valid_s2 <= tag_s1.chroma_valid;
			chroma_blue_s2  <= chroma_blue_c;
			chroma_red_s2   <= chroma_red_c;
			frame_end_s2    <= tag_s1.frame_end;
		end
	end

	assign pixel_out.valid        = valid_s2;
	assign pixel_out.luma         = luma_s2;
	assign pixel_out.chroma_valid = chroma_valid_s2;
	assign pixel_out.chroma_blue  = chroma_blue_s2;
	assign pixel_out.chroma_red   = chroma_red_s2;
	assign pixel_out.frame_end    = frame_end_s2;

endmodule

`default_nettype wire

/* bench/rgb_to_yuv420_converter_test.sv */
// self-checking testbench for the rgb888 to yuv 4:2:0 converter
`timescale 1ns / 1ps

module rgb_to_yuv420_converter_test;
	import yuv420_pkg::*;

	localparam int CLK_HALF       = 5;
	localparam int MAX_GAP        = 18;
	localparam int HOLD_CYCLES    = 80;
	localparam int SETTLE_CYCLES  = 4;
	localparam int IDLE_LIMIT     = 2000;
	localparam int TOTAL_PIXELS   = 1800;
	localparam int WIDE_PIXELS    = 256;
	localparam int CFG_DATA_MAX   = (1 << CFG_DATA_W) - 1;

	// index past the register list, writes to it are ignored
	localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

	typedef struct packed {
		logic [COMP_W-1:0] luma;
		logic              chroma_valid;
		logic [COMP_W-1:0] chroma_blue;
		logic [COMP_W-1:0] chroma_red;
		logic              frame_end;
	} yuv_result_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	yuv420_rgb_if pixel_in_if();
	yuv420_yuv_if pixel_out_if();

	int  src_idle_max  = 0;
	int  sink_idle_max = 0;
	int  sink_gap      = 0;
	bit  hold_request  = 1'b0;
	int  idle_cycles   = 0;

	rgb_to_yuv420_converter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixel_in  (pixel_in_if),
		.pixel_out (pixel_out_if)
	);

	// register value to the dimension the block really uses
	function automatic int unsigned dim_in_use(logic [CFG_DATA_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_DIMENSION_DEF)
			return MAX_DIMENSION_DEF;
		return v;
	endfunction

	function automatic logic [COMP_W-1:0] sat8(int v);
		if (v < 0)
			return '0;
		if (v > SAT_MAX)
			return COMP_W'(SAT_MAX);
		return v[COMP_W-1:0];
	endfunction

	// geometry, raster position and the yuv results still owed by the block
	class yuv_frame_tracker;
		logic [CFG_DATA_W-1:0] width_reg;
		logic [CFG_DATA_W-1:0] height_reg;
		int unsigned           col;
		int unsigned           row;
		yuv_result_t           pending_yuv[$];
		int unsigned           mismatches;
		int unsigned           in_pixels;

		function new();
			width_reg   = CFG_DATA_W'(IMAGE_WIDTH_RST);
			height_reg  = CFG_DATA_W'(IMAGE_HEIGHT_RST);
			col         = 0;
			row         = 0;
			mismatches  = 0;
			in_pixels   = 0;
		endfunction

		// any write to a real register restarts the frame
		function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
			if (index == REG_IMAGE_WIDTH)
				width_reg = data;
			else if (index == REG_IMAGE_HEIGHT)
				height_reg = data;
			else
				return;
			col = 0;
			row = 0;
		endfunction

		function void accept_pixel(logic [COMP_W-1:0] r, logic [COMP_W-1:0] g,
			logic [COMP_W-1:0] b);
			int unsigned w;
			int unsigned h;
			int unsigned w_even;
			int unsigned h_even;
			int          ri;
			int          gi;
			int          bi;
			yuv_result_t res;
			w      = dim_in_use(width_reg);
			h      = dim_in_use(height_reg);
			w_even = w - (w % 2);
			h_even = h - (h % 2);
			ri     = int'(r);
			gi     = int'(g);
			bi     = int'(b);
			// only pixels inside the even-cropped frame give a result
			if (col < w_even && row < h_even) begin
				res.luma         = sat8(((Y_R * ri + Y_G * gi + Y_B * bi + ROUND) >>> SHIFT) + Y_OFS);
				res.chroma_valid = (col % 2 == 0) && (row % 2 == 0);
				res.chroma_blue  = '0;
				res.chroma_red   = '0;
				if (res.chroma_valid) begin
					res.chroma_blue = sat8(((CB_B * bi - CB_R * ri - CB_G * gi + ROUND) >>> SHIFT)
						+ C_OFS);
					res.chroma_red  = sat8(((CR_R * ri - CR_G * gi - CR_B * bi + ROUND) >>> SHIFT)
						+ C_OFS);
				end
				res.frame_end = (col == w_even - 1) && (row == h_even - 1);
				pending_yuv.push_back(res);
			end
			in_pixels++;
			// advance the raster position over the uncropped frame
			if (col + 1 >= w) begin
				col = 0;
				row = (row + 1 >= h) ? 0 : row + 1;
			end else begin
				col++;
			end
		endfunction

		function void check_yuv(yuv_result_t got);
			yuv_result_t want;
			if (pending_yuv.size() == 0) begin
				$error("unexpected output: luma %0d frame_end %0b", got.luma, got.frame_end);
				mismatches++;
				return;
			end
			want = pending_yuv.pop_front();
			if (got.luma !== want.luma) begin
				$error("luma: expected %0d, actual %0d", want.luma, got.luma);
				mismatches++;
			end
			if (got.chroma_valid !== want.chroma_valid) begin
				$error("chroma_valid: expected %0b, actual %0b", want.chroma_valid,
					got.chroma_valid);
				mismatches++;
			end
			if (got.chroma_blue !== want.chroma_blue) begin
				$error("chroma_blue: expected %0d, actual %0d", want.chroma_blue, got.chroma_blue);
				mismatches++;
			end
			if (got.chroma_red !== want.chroma_red) begin
				$error("chroma_red: expected %0d, actual %0d", want.chroma_red, got.chroma_red);
				mismatches++;
			end
			if (got.frame_end !== want.frame_end) begin
				$error("frame_end: expected %0b, actual %0b", want.frame_end, got.frame_end);
				mismatches++;
			end
		endfunction
	endclass

	yuv_frame_tracker frames;

	// clock
	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// sample both channels at the rising edge
	always @(posedge clk) begin : sample
		yuv_result_t got;
		bit          in_xfer;
		bit          out_xfer;
		in_xfer  = pixel_in_if.valid && pixel_in_if.ready;
		out_xfer = pixel_out_if.valid && pixel_out_if.ready;
		if (in_xfer)
			frames.accept_pixel(pixel_in_if.red, pixel_in_if.green, pixel_in_if.blue);
		if (out_xfer) begin
			got.luma         = pixel_out_if.luma;
			got.chroma_valid = pixel_out_if.chroma_valid;
			got.chroma_blue  = pixel_out_if.chroma_blue;
			got.chroma_red   = pixel_out_if.chroma_red;
			got.frame_end    = pixel_out_if.frame_end;
			frames.check_yuv(got);
			sink_gap = $urandom_range(0, sink_idle_max);
		end
		if (in_xfer || out_xfer)
			idle_cycles = 0;
		else
			idle_cycles++;
	end

	// output ready: wait out the drawn gap or a long hold, then accept
	always @(negedge clk) begin
		if (hold_request) begin
			sink_gap     = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (sink_gap > 0) begin
			pixel_out_if.ready <= 1'b0;
			sink_gap--;
		end else begin
			pixel_out_if.ready <= 1'b1;
		end
	end

	// watchdog on cycles without any transfer
	initial begin
		wait (idle_cycles >= IDLE_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	// offer one pixel after a random gap, return at its transfer with valid still high
	task automatic send_pixel(logic [COMP_W-1:0] r, logic [COMP_W-1:0] g, logic [COMP_W-1:0] b);
		int gap;
		gap = $urandom_range(0, src_idle_max);
		@(negedge clk);
		if (gap > 0) begin
			pixel_in_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pixel_in_if.valid <= 1'b1;
		pixel_in_if.red   <= r;
		pixel_in_if.green <= g;
		pixel_in_if.blue  <= b;
		do @(posedge clk); while (!pixel_in_if.ready);
	endtask

	task automatic release_input();
		@(negedge clk);
		pixel_in_if.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (frames.pending_yuv.size() != 0)
			@(posedge clk);
	endtask

	// stop offering, collect every result and let dropped pixels clear the pipe
	task automatic settle();
		release_input();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(posedge clk);
		frames.write_reg(index, data);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_geometry(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
		settle();
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
	endtask

	function automatic logic [COMP_W-1:0] random_component();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return COMP_W'($urandom_range(0, SAT_MAX));
		endcase
	endfunction

	function automatic int pick_idle();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return $urandom_range(1, MAX_GAP);
			default: return MAX_GAP;
		endcase
	endfunction

	// random pixels, with an optional pause until all results are back
	task automatic send_random_pixels(int count, int pause_at);
		for (int i = 0; i < count; i++) begin
			if (i == pause_at) begin
				release_input();
				wait_drained();
			end
			send_pixel(random_component(), random_component(), random_component());
		end
	endtask

	initial begin
		logic [23:0]  colors [21];
		int unsigned  w;
		int unsigned  h;
		int           count;

		arst_n                   = 1'b0;
		cfg_we                   = 1'b0;
		cfg_index                = REG_IMAGE_WIDTH;
		cfg_data                 = '0;
		pixel_in_if.valid        = 1'b0;
		pixel_in_if.red          = '0;
		pixel_in_if.green        = '0;
		pixel_in_if.blue         = '0;
		pixel_out_if.ready       = 1'b0;
		frames                   = new();

		colors = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
			24'hFFFF00, 24'hFF00FF, 24'h00FFFF, 24'h808080, 24'h010101, 24'hFEFEFE,
			24'h00FFFF, 24'hFF0000, 24'h0000FF, 24'hFFFF00, 24'h7F7F7F, 24'h55AA55,
			24'hAA55AA, 24'h123456, 24'hEDCBA9, 24'h000000};

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset geometry, extreme and primary colors
		src_idle_max  = MAX_GAP;
		sink_idle_max = MAX_GAP;
		foreach (colors[i])
			send_pixel(colors[i][23:16], colors[i][15:8], colors[i][7:0]);

		// write past the register list: position must carry on at an odd column
		settle();
		write_reg(CFG_UNUSED_INDEX, CFG_DATA_W'(CFG_DATA_MAX));
		send_random_pixels(3, -1);

		// zero dimensions act as one: empty frame
		set_geometry(0, 0);
		send_random_pixels(3, -1);

		// oversized width, single row: still empty after cropping
		set_geometry(CFG_DATA_W'(CFG_DATA_MAX), 1);
		send_random_pixels(5, -1);

		// one column only: empty frame
		set_geometry(1, 4);
		send_random_pixels(4, -1);

		// odd sizes drop the last column and row, two frames to see the wrap
		set_geometry(3, 3);
		send_random_pixels(18, -1);

		// smallest kept frame
		set_geometry(2, 2);
		send_random_pixels(12, -1);

		// clamped width, start of a wide frame
		src_idle_max  = 1;
		sink_idle_max = 1;
		set_geometry(CFG_DATA_W'(CFG_DATA_MAX), 2);
		send_random_pixels(WIDE_PIXELS, -1);

		// clamped height, start of a tall frame
		src_idle_max  = MAX_GAP;
		sink_idle_max = MAX_GAP;
		set_geometry(2, CFG_DATA_W'(MAX_DIMENSION_DEF + 1));
		send_random_pixels(40, -1);

		// output held off while input keeps coming, then a drained pause mid-frame
		set_geometry(4, 4);
		src_idle_max  = 0;
		sink_idle_max = 0;
		@(posedge clk);
		hold_request = 1'b1;
		send_random_pixels(32, 20);

		// random geometries, mostly whole frames
		while (frames.in_pixels < TOTAL_PIXELS) begin
			case ($urandom_range(0, 9))
				0: begin
					w     = $urandom_range(0, 1);
					h     = $urandom_range(0, 6);
					count = $urandom_range(1, 20);
				end
				1: begin
					w     = $urandom_range(0, 6);
					h     = $urandom_range(0, 1);
					count = $urandom_range(1, 20);
				end
				2: begin
					w     = $urandom_range(13, 700);
					h     = $urandom_range(1, 4);
					count = $urandom_range(1, 300);
				end
				3: begin
					w     = $urandom_range(MAX_DIMENSION_DEF + 1, CFG_DATA_MAX);
					h     = $urandom_range(1, 3);
					count = $urandom_range(1, 60);
				end
				default: begin
					w     = $urandom_range(2, 12);
					h     = $urandom_range(2, 10);
					count = $urandom_range(1, 3) * w * h;
					if ($urandom_range(0, 3) == 0)
						count += $urandom_range(1, 2 * w);
				end
			endcase
			set_geometry(CFG_DATA_W'(w), CFG_DATA_W'(h));
			if ($urandom_range(0, 5) == 0)
				write_reg(CFG_UNUSED_INDEX, CFG_DATA_W'($urandom_range(0, CFG_DATA_MAX)));
			src_idle_max  = pick_idle();
			sink_idle_max = pick_idle();
			send_random_pixels(count,
				($urandom_range(0, 3) == 0) ? $urandom_range(0, count - 1) : -1);
		end

		// drain and watch for stray results
		release_input();
		wait_drained();
		repeat (4 * SETTLE_CYCLES) @(posedge clk);
		if (frames.mismatches == 0 && frames.pending_yuv.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* rgb_to_yuv420_converter.f */
hw/rtl/yuv420_pkg.sv
hw/rtl/yuv420_if.sv
hw/rtl/yuv420_pos.sv
hw/rtl/yuv420_csc.sv
hw/rtl/rgb_to_yuv420_converter.sv
bench/rgb_to_yuv420_converter_test.sv
